/* src/i2cm_pkg.sv */
// Shared widths, command codes and reset values for the I2C master byte engine.
`default_nettype none
package i2cm_pkg;

	localparam int CMD_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int HP_W    = 10;
	localparam int BIT_W   = 4;

	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

	localparam logic [HP_W-1:0]  HALF_PERIOD_RESET = 10'd10;
	localparam logic [BIT_W-1:0] BYTE_BITS         = 4'd8;

endpackage
`default_nettype wire

/* src/i2cm_item_if.sv */
// Input channel: one timebase tick with an optional command.
`default_nettype none
interface i2cm_item_if
	import i2cm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] write_byte;
	logic              read_is_last;
	logic              sda_in;

	modport source (output valid, cmd, write_byte, read_is_last, sda_in, input ready);
	modport sink   (input valid, cmd, write_byte, read_is_last, sda_in, output ready);
endinterface
`default_nettype wire

/* src/i2cm_result_if.sv */
// Result channel: pin drives and status after one tick.
`default_nettype none
interface i2cm_result_if
	import i2cm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              scl_out;
	logic              sda_out;
	logic              busy_res;
	logic              done_res;
	logic [BYTE_W-1:0] read_data;
	logic              nack_seen;
	logic              cmd_rejected;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
		nack_seen, cmd_rejected, input ready);
	modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
		nack_seen, cmd_rejected, output ready);
endinterface
`default_nettype wire

/* src/i2c_master_byte_engine.sv */
// I2C master byte engine: per-tick sequencer for start, stop, restart, write and read.
// Result: the result of a tick is in the result register in the cycle after it is accepted.
// Throughput: one tick per cycle; the single result register takes a new request
// whenever it is empty or its result is taken in the same cycle.
// Edge spacing is set by the half-period counter, reloaded after each non-final pin action.
// Reset (arst_n low, asynchronous): engine idle, SCL and SDA released, status and
// read byte cleared, half period back to 10, result register empty.
`default_nettype none
module i2c_master_byte_engine
	import i2cm_pkg::*;
#(
	parameter int COUNT_WIDTH = 10
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [HP_W-1:0] cfg_wdata,
	i2cm_item_if.sink            item,
	i2cm_result_if.source        result
);

	localparam int unsigned CNT_MAX = (1 << COUNT_WIDTH) - 1;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_FIN,
		PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D,
		PH_RS_A, PH_RS_B, PH_RS_C, PH_RS_D,
		PH_WR_SET, PH_WR_HIGH, PH_WR_ACK,
		PH_RD_HIGH, PH_RD_SAMP, PH_RD_ACK, PH_RD_ACKHI, PH_RD_ACKLO, PH_RD_END
	} phase_t;

	phase_t                 phase_q;
	logic [BIT_W-1:0]       bit_q;
	logic [BYTE_W-1:0]      shift_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   scl_q;
	logic                   sda_q;
	logic                   ack_q;
	logic                   last_q;
	logic [BYTE_W-1:0]      read_hold_q;
	logic [HP_W-1:0]        half_period_q;
	logic                   res_valid_q;
	logic                   done_q;
	logic                   rejected_q;

	logic                   accept;
	logic                   busy;
	logic                   cmd_valid;
	logic                   do_act;
	phase_t                 act_phase;
	phase_t                 start_phase;
	logic [BIT_W-1:0]       act_bit;
	logic [BYTE_W-1:0]      act_shift;
	logic                   act_last;
	logic [HP_W-1:0]        wait_m1;
	logic [COUNT_WIDTH-1:0] wait_load;

	phase_t                 n_phase;
	logic [BIT_W-1:0]       n_bit;
	logic [BYTE_W-1:0]      n_shift;
	logic [COUNT_WIDTH-1:0] n_cnt;
	logic                   n_scl;
	logic                   n_sda;
	logic                   n_ack;
	logic [BYTE_W-1:0]      n_read_hold;
	logic                   n_done;
	logic [BIT_W-1:0]       bit_inc;

	// Take a request whenever the result register is free or drains this cycle
	assign accept     = item.valid && item.ready;
	assign item.ready = !res_valid_q || result.ready;

	assign busy      = (phase_q != PH_IDLE);
	assign cmd_valid = (item.cmd == CMD_START) || (item.cmd == CMD_STOP) ||
		(item.cmd == CMD_RESTART) || (item.cmd == CMD_WRITE) || (item.cmd == CMD_READ);

	// Wait reload: zero half period acts as one, saturate at the counter range
	assign wait_m1   = (half_period_q == '0) ? '0 : half_period_q - 1'b1;
	assign wait_load = (32'(wait_m1) > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX)
		: COUNT_WIDTH'(wait_m1);

	// Map an idle command to the first phase of its sequence
	always_comb begin
		unique case (item.cmd)
			CMD_START:   start_phase = PH_ST_A;
			CMD_STOP:    start_phase = PH_SP_A;
			CMD_RESTART: start_phase = PH_RS_A;
			CMD_WRITE:   start_phase = PH_WR_SET;
			CMD_READ:    start_phase = PH_RD_HIGH;
			default:     start_phase = PH_IDLE;
		endcase
	end

	// Select the state the action works on: running sequence or a fresh command
	always_comb begin
		if (busy) begin
			act_phase = phase_q;
			act_bit   = bit_q;
			act_shift = shift_q;
			act_last  = last_q;
			do_act    = (cnt_q == '0);
		end else begin
			act_phase = start_phase;
			act_bit   = '0;
			act_shift = (item.cmd == CMD_WRITE) ? item.write_byte : '0;
			act_last  = (item.cmd == CMD_READ) ? item.read_is_last : last_q;
			do_act    = cmd_valid;
		end
	end

	assign bit_inc = act_bit + 1'b1;

	// Pin action of the current phase, or count down the wait
	always_comb begin
		n_phase     = busy ? phase_q : PH_IDLE;
		n_bit       = busy ? bit_q : (cmd_valid ? act_bit : bit_q);
		n_shift     = busy ? shift_q : (cmd_valid ? act_shift : shift_q);
		n_cnt       = cnt_q;
		n_scl       = scl_q;
		n_sda       = sda_q;
		n_ack       = ack_q;
		n_read_hold = read_hold_q;
		n_done      = 1'b0;
		if (busy && cnt_q != '0) begin
			n_cnt = cnt_q - 1'b1;
		end else if (do_act) begin
			n_cnt = wait_load;
			unique case (act_phase)
				PH_ST_A: begin n_sda = 1'b0; n_phase = PH_ST_B; end
				PH_ST_B: begin n_scl = 1'b0; n_phase = PH_FIN; end
				PH_SP_A: begin n_scl = 1'b0; n_phase = PH_SP_B; end
				PH_SP_B: begin n_sda = 1'b0; n_phase = PH_SP_C; end
				PH_SP_C: begin n_scl = 1'b1; n_phase = PH_SP_D; end
				PH_SP_D: begin n_sda = 1'b1; n_phase = PH_FIN; end
				PH_RS_A: begin n_sda = 1'b1; n_phase = PH_RS_B; end
				PH_RS_B: begin n_scl = 1'b1; n_phase = PH_RS_C; end
				PH_RS_C: begin n_sda = 1'b0; n_phase = PH_RS_D; end
				PH_RS_D: begin n_scl = 1'b0; n_phase = PH_FIN; end
				PH_FIN: begin
					n_cnt   = cnt_q;
					n_phase = PH_IDLE;
					n_done  = 1'b1;
				end
				PH_WR_SET: begin
					if (act_bit != '0) begin
						n_scl = 1'b0;
					end
					n_sda   = (act_bit >= BYTE_BITS) ? 1'b1 : act_shift[BYTE_W-1];
					n_phase = PH_WR_HIGH;
				end
				PH_WR_HIGH: begin
					n_scl = 1'b1;
					if (act_bit >= BYTE_BITS) begin
						n_phase = PH_WR_ACK;
					end else begin
						n_shift = {act_shift[BYTE_W-2:0], 1'b0};
						n_bit   = bit_inc;
						n_phase = PH_WR_SET;
					end
				end
				PH_WR_ACK: begin
					n_cnt   = cnt_q;
					n_ack   = item.sda_in;
					n_scl   = 1'b0;
					n_phase = PH_IDLE;
					n_done  = 1'b1;
				end
				PH_RD_HIGH: begin
					n_sda   = 1'b1;
					n_scl   = 1'b1;
					n_phase = PH_RD_SAMP;
				end
				PH_RD_SAMP: begin
					n_shift = {act_shift[BYTE_W-2:0], item.sda_in};
					n_scl   = 1'b0;
					n_bit   = bit_inc;
					n_phase = (bit_inc >= BYTE_BITS) ? PH_RD_ACK : PH_RD_HIGH;
				end
				PH_RD_ACK:   begin n_sda = act_last; n_phase = PH_RD_ACKHI; end
				PH_RD_ACKHI: begin n_scl = 1'b1; n_phase = PH_RD_ACKLO; end
				PH_RD_ACKLO: begin n_scl = 1'b0; n_phase = PH_RD_END; end
				PH_RD_END: begin
					n_cnt       = cnt_q;
					n_sda       = 1'b1;
					n_read_hold = act_shift;
					n_phase     = PH_IDLE;
					n_done      = 1'b1;
				end
				default: begin
					n_cnt   = cnt_q;
					n_phase = PH_IDLE;
				end
			endcase
		end
	end

	// Engine and result registers; engine state advances only on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_q         <= '0;
			shift_q       <= '0;
			cnt_q         <= '0;
			scl_q         <= 1'b1;
			sda_q         <= 1'b1;
			ack_q         <= 1'b0;
			last_q        <= 1'b0;
			read_hold_q   <= '0;
			half_period_q <= HALF_PERIOD_RESET;
			res_valid_q   <= 1'b0;
			done_q        <= 1'b0;
			rejected_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				half_period_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q     <= n_phase;
				bit_q       <= n_bit;
				shift_q     <= n_shift;
				cnt_q       <= n_cnt;
				scl_q       <= n_scl;
				sda_q       <= n_sda;
				ack_q       <= n_ack;
				last_q      <= act_last;
				read_hold_q <= n_read_hold;
				done_q      <= n_done;
				rejected_q  <= busy && cmd_valid;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Drive the result channel from the registered state
	assign result.valid        = res_valid_q;
	assign result.scl_out      = scl_q;
	assign result.sda_out      = sda_q;
	assign result.busy_res     = busy;
	assign result.done_res     = done_q;
	assign result.read_data    = read_hold_q;
	assign result.nack_seen    = ack_q;
	assign result.cmd_rejected = rejected_q;

endmodule
`default_nettype wire
